@@ hw/rtl/srfp_pkg.sv @@
// Shared types and constants for the sonar range frame parser.
`default_nettype none

package srfp_pkg;

    localparam int RANGE_W  = 14;
    localparam int RANGE_MAX = 16383;
    localparam int STATUS_W = 2;
    localparam int BYTE_W   = 8;

    localparam logic [BYTE_W-1:0] START_CHAR = 8'h52;
    localparam logic [BYTE_W-1:0] CR_CHAR    = 8'h0D;
    localparam logic [BYTE_W-1:0] DIGIT_LO   = 8'h30;
    localparam logic [BYTE_W-1:0] DIGIT_HI   = 8'h39;

    localparam logic [1:0] PHASE_COLLECT    = 2'd0;
    localparam logic [1:0] PHASE_COLLECT_CR = 2'd1;
    localparam logic [1:0] PHASE_HUNT       = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_TIMEOUT = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FORMAT  = 2'd2;

    typedef struct packed {
        logic              valid;
        logic              mode;
        logic [BYTE_W-1:0] rx_byte;
    } t_beat;

    typedef struct packed {
        logic                valid;
        logic [RANGE_W-1:0]  range_value;
        logic [RANGE_W-1:0]  average_value;
        logic [STATUS_W-1:0] status;
    } t_result;

endpackage

`default_nettype wire

@@ hw/rtl/srfp_in_reg.sv @@
// Input register stage for received bytes and timeout events.
`default_nettype none

module srfp_in_reg
    import srfp_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire logic              i_mode,
    input  wire logic [BYTE_W-1:0] i_rx_byte,
    input  wire logic              i_advance,
    output t_beat                  o_beat
);

    logic              r_valid;
    logic              r_mode;
    logic [BYTE_W-1:0] r_rx_byte;

    // free slot, or the held beat moves on in this cycle
    assign o_ready = !r_valid || i_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_mode    <= i_mode;
            r_rx_byte <= i_rx_byte;
        end
    end

    assign o_beat = '{valid: r_valid, mode: r_mode, rx_byte: r_rx_byte};

endmodule

`default_nettype wire

@@ hw/rtl/srfp_core.sv @@
// Frame parser state, digit accumulation and moving-average ring.
`default_nettype none

module srfp_core
    import srfp_pkg::*;
#(
    parameter int TAPS        = 5,
    parameter int FRAME_BYTES = 6,
    parameter int DIGIT_COUNT = 4
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_en,
    input  wire t_beat i_beat,
    output t_result    o_result
);

    localparam int PW    = $clog2(FRAME_BYTES);
    localparam int IW    = (TAPS > 1) ? $clog2(TAPS) : 1;
    localparam int SW    = $clog2(RANGE_MAX / TAPS + 1);
    // ceiling reciprocal, exact for every 14-bit dividend and divisor up to 16
    localparam int K     = RANGE_W + 4;
    localparam int RECIP = (2 ** K + TAPS - 1) / TAPS;
    localparam int PRW   = RANGE_W + K + 1;

    logic [PW-1:0]      r_pos,   n_pos;
    logic [1:0]         r_phase, n_phase;
    logic               r_blk,   n_blk;
    logic               r_derr,  n_derr;
    logic [RANGE_W-1:0] r_acc,   n_acc;
    logic [RANGE_W-1:0] r_sum,   n_sum;
    logic [IW-1:0]      r_idx,   n_idx;
    logic [SW-1:0]      r_ring [TAPS];
    logic [SW-1:0]      n_ring [TAPS];

    logic [PRW-1:0]     prod;
    logic [SW-1:0]      quot;
    logic [RANGE_W-1:0] acc_x10;
    logic               is_digit;
    logic               blk;
    logic [1:0]         ph;

    // on the last byte the accumulator already holds the final range
    assign prod    = PRW'(r_acc) * PRW'(RECIP);
    assign quot    = prod[K +: SW];
    assign acc_x10 = (r_acc << 3) + (r_acc << 1)
                   + {{(RANGE_W-4){1'b0}}, i_beat.rx_byte[3:0]};

    always_comb begin
        n_pos    = r_pos;
        n_phase  = r_phase;
        n_blk    = r_blk;
        n_derr   = r_derr;
        n_acc    = r_acc;
        n_sum    = r_sum;
        n_idx    = r_idx;
        n_ring   = r_ring;
        o_result = '0;
        is_digit = i_beat.rx_byte inside {[DIGIT_LO:DIGIT_HI]};
        blk      = r_blk;
        ph       = r_phase;

        if (i_beat.mode) begin
            n_pos   = '0;
            n_phase = PHASE_COLLECT;
            n_blk   = 1'b0;
            n_derr  = 1'b0;
            n_acc   = '0;
            o_result.valid  = 1'b1;
            o_result.status = STATUS_TIMEOUT;
        end else if (r_phase == PHASE_HUNT) begin
            if (i_beat.rx_byte == CR_CHAR) begin
                n_pos   = '0;
                n_phase = PHASE_COLLECT;
                n_blk   = 1'b0;
                n_derr  = 1'b0;
                n_acc   = '0;
            end
        end else begin
            if (r_pos == '0) begin
                blk    = (i_beat.rx_byte == START_CHAR);
                n_derr = 1'b0;
                n_acc  = '0;
                ph     = (!blk && i_beat.rx_byte == CR_CHAR) ? PHASE_COLLECT_CR
                                                              : PHASE_COLLECT;
            end else if (r_pos <= PW'(DIGIT_COUNT)) begin
                if (is_digit) begin
                    n_acc = acc_x10;
                end else begin
                    n_derr = 1'b1;
                end
            end
            n_blk   = blk;
            n_phase = ph;

            if (r_pos != PW'(FRAME_BYTES - 1)) begin
                n_pos = r_pos + 1'b1;
            end else begin
                n_pos = '0;
                if (!blk) begin
                    n_phase = (ph == PHASE_COLLECT_CR) ? PHASE_COLLECT : PHASE_HUNT;
                end else begin
                    n_phase = PHASE_COLLECT;
                    n_blk   = 1'b0;
                    n_acc   = '0;
                    o_result.valid = 1'b1;
                    if (r_derr) begin
                        n_derr = 1'b0;
                        o_result.status = STATUS_FORMAT;
                    end else begin
                        n_ring[r_idx] = quot;
                        n_idx = (r_idx == IW'(TAPS - 1)) ? '0 : r_idx + 1'b1;
                        // running sum: drop the overwritten sample, add the new one
                        n_sum = r_sum - RANGE_W'(r_ring[r_idx]) + RANGE_W'(quot);
                        o_result.range_value   = r_acc;
                        o_result.average_value = n_sum;
                        o_result.status        = STATUS_OK;
                    end
                end
            end
        end
        o_result.valid = o_result.valid && i_beat.valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_phase <= PHASE_COLLECT;
            r_blk   <= 1'b0;
            r_derr  <= 1'b0;
            r_acc   <= '0;
            r_sum   <= '0;
            r_idx   <= '0;
            for (int k = 0; k < TAPS; k++) begin
                r_ring[k] <= '0;
            end
        end else if (i_en) begin
            r_pos   <= n_pos;
            r_phase <= n_phase;
            r_blk   <= n_blk;
            r_derr  <= n_derr;
            r_acc   <= n_acc;
            r_sum   <= n_sum;
            r_idx   <= n_idx;
            r_ring  <= n_ring;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/srfp_out_reg.sv @@
// Result register holding one beat for the downstream receiver.
`default_nettype none

module srfp_out_reg
    import srfp_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_load,
    input  wire t_result i_result,
    input  wire logic    i_ready,
    output logic         o_valid,
    output logic         o_free,
    output t_result      o_result
);

    logic    r_valid;
    t_result r_result;

    assign o_free = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= i_result.valid;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && i_result.valid) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

`default_nettype wire

@@ hw/rtl/sonar_range_frame_parser_unit.sv @@
// Top level of the sonar range frame parser.
// Input stream: one beat per received serial byte (tuser = 0) or per read
// timeout / short frame event (tuser = 1). Bytes are grouped into frames;
// a frame starting with 'R' carries ASCII range digits and yields one
// result beat with the range, the moving average over the sample ring and
// a status (tuser): valid or format error. Other frames are dropped and the
// parser hunts for a carriage return, unless the frame began with one.
// Every timeout beat yields a result beat with status timeout; plain bytes
// yield none except on the last byte of a frame starting with 'R'.
// A result is presented on the master side after passing through the input
// register, then the result register.
// Throughput: one beat per cycle unless the receiver stalls; the digit,
// divide-by-TAPS and running-sum update share one stage between registers.
// Reset clears the frame state, the sample ring and both valid flags.
// When the receiver stalls, the result beat is held and one further input
// beat is taken into the input register; s_axis_tready then falls until
// the result is taken.
`default_nettype none

module sonar_range_frame_parser_unit
    import srfp_pkg::*;
#(
    parameter int TAPS        = 5,
    parameter int FRAME_BYTES = 6,
    parameter int DIGIT_COUNT = 4
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    input  wire logic        s_axis_tuser,   // [0] mode
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,   // [13:0] range_value, [27:14] average_value
    output logic [1:0]       m_axis_tuser    // [1:0] status
);

    t_beat   beat;
    t_result core_result;
    t_result out_result;
    logic    out_free;
    logic    advance;

    assign advance = beat.valid && out_free;

    srfp_in_reg u_in_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_axis_tvalid),
        .o_ready   (s_axis_tready),
        .i_mode    (s_axis_tuser),
        .i_rx_byte (s_axis_tdata),
        .i_advance (advance),
        .o_beat    (beat)
    );

    srfp_core #(
        .TAPS        (TAPS),
        .FRAME_BYTES (FRAME_BYTES),
        .DIGIT_COUNT (DIGIT_COUNT)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (advance),
        .i_beat   (beat),
        .o_result (core_result)
    );

    srfp_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (advance),
        .i_result (core_result),
        .i_ready  (m_axis_tready),
        .o_valid  (m_axis_tvalid),
        .o_free   (out_free),
        .o_result (out_result)
    );

    assign m_axis_tdata = {4'b0000, out_result.average_value, out_result.range_value};
    assign m_axis_tuser = out_result.status;

endmodule

`default_nettype wire

@@ hw/rtl/srfp_checker.sv @@
// Port-level checks for the sonar range frame parser, bound to the top level.
`default_nettype none

module srfp_checker
    import srfp_pkg::*;
(
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [31:0] m_axis_tdata,
    input wire logic [1:0]  m_axis_tuser
);

    // nothing leaves the block in the cycle after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result beat presented straight after reset");

    // a ready receiver never backs up the input side
    a_no_bubble: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tready |-> s_axis_tready)
        else $error("input stalled while receiver ready");

    // error beats carry no range or average
    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser != STATUS_OK |-> m_axis_tdata == 32'd0)
        else $error("error beat with nonzero payload");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result beat changed");

endmodule

bind sonar_range_frame_parser_unit srfp_checker u_srfp_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
